FILE: rtl/core/script_text_normalizer_macros.svh
// ----------------------------------------------------------------------------
// Script text normalizer assertion macros
// Concurrent assertion wrappers on clk and rst_n. They compile to nothing
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TEXT_NORMALIZER_MACROS_SVH
`define SCRIPT_TEXT_NORMALIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define STN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define STN_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define STN_ASSERT(label, prop, msg)

`define STN_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: rtl/core/stn_pkg.sv
// ----------------------------------------------------------------------------
// Script text normalizer package
// Decoder modes, byte codes, queue sizing and the run entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package stn_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] BYTE_NUL  = 8'h00;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_SP   = 8'h20;
  localparam logic [7:0] BYTE_LT   = 8'h3C;
  localparam logic [7:0] BYTE_EQ   = 8'h3D;
  localparam logic [7:0] BYTE_GT   = 8'h3E;
  localparam logic [7:0] BYTE_80   = 8'h80;
  localparam logic [7:0] BYTE_89   = 8'h89;
  localparam logic [7:0] BYTE_A0   = 8'hA0;
  localparam logic [7:0] BYTE_A4   = 8'hA4;
  localparam logic [7:0] BYTE_A5   = 8'hA5;
  localparam logic [7:0] BYTE_AC   = 8'hAC;
  localparam logic [7:0] BYTE_AD   = 8'hAD;
  localparam logic [7:0] BYTE_B2   = 8'hB2;
  localparam logic [7:0] BYTE_B3   = 8'hB3;
  localparam logic [7:0] BYTE_BF   = 8'hBF;
  localparam logic [7:0] BYTE_C2   = 8'hC2;
  localparam logic [7:0] BYTE_E0   = 8'hE0;
  localparam logic [7:0] BYTE_E2   = 8'hE2;
  localparam logic [7:0] BYTE_F0   = 8'hF0;
  localparam logic [7:0] BYTE_F4   = 8'hF4;

  typedef enum logic [6:0] {
    MODE_NORMAL   = 7'b0000001,
    MODE_AFTER_C2 = 7'b0000010,
    MODE_BLANKS   = 7'b0000100,
    MODE_AFTER_E2 = 7'b0001000,
    MODE_E2_89    = 7'b0010000,
    MODE_COPY     = 7'b0100000,
    MODE_AFTER_CR = 7'b1000000
  } mode_t;

  // All result bytes caused by one input transaction.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       done;
  } run_t;

endpackage

`default_nettype wire

FILE: rtl/core/stn_front.sv
// ----------------------------------------------------------------------------
// Script text normalizer front end
// Decodes one input byte per cycle unless the queue is full; pushes its run.
// ----------------------------------------------------------------------------
`default_nettype none

module stn_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_end_of_text,
  input  wire logic          q_full,
  output logic               q_push,
  output stn_pkg::run_t      q_run,
  output stn_pkg::mode_t     front_mode
);
  import stn_pkg::*;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] rem;
    run_t       run;
  } dec_t;

  mode_t      mode_r, mode_nxt;
  logic [1:0] rem_r, rem_nxt;
  run_t       run;
  logic       accept;

  function automatic dec_t normal_fn(input logic [7:0] b, input logic [1:0] rem);
    dec_t d;
    d      = '0;
    d.mode = MODE_NORMAL;
    d.rem  = rem;
    if (b == BYTE_C2) begin
      d.mode = MODE_AFTER_C2;
    end else if (b == BYTE_E2) begin
      d.mode = MODE_AFTER_E2;
    end else if (b == BYTE_AD) begin
      d.run.cnt = 2'd2; d.run.b0 = BYTE_LT; d.run.b1 = BYTE_GT;
    end else if (b == BYTE_B2) begin
      d.run.cnt = 2'd2; d.run.b0 = BYTE_LT; d.run.b1 = BYTE_EQ;
    end else if (b == BYTE_B3) begin
      d.run.cnt = 2'd2; d.run.b0 = BYTE_GT; d.run.b1 = BYTE_EQ;
    end else if (b >= BYTE_C2 && b <= BYTE_F4) begin
      d.run.cnt = 2'd1; d.run.b0 = b;
      d.rem     = (b >= BYTE_F0) ? 2'd3 : ((b >= BYTE_E0) ? 2'd2 : 2'd1);
      d.mode    = MODE_COPY;
    end else if (b == BYTE_CR) begin
      d.run.cnt = 2'd1; d.run.b0 = BYTE_LF;
      d.mode    = MODE_AFTER_CR;
    end else begin
      d.run.cnt = 2'd1; d.run.b0 = b;
    end
    return d;
  endfunction

  // After a continuation mark: blanks are swallowed, anything else closes
  // the continuation with one space.
  function automatic dec_t blank_fn(input logic [7:0] b, input logic [1:0] rem);
    dec_t d;
    dec_t n;
    d      = '0;
    d.rem  = rem;
    n      = normal_fn(b, rem);
    if (b == BYTE_SP || b == BYTE_TAB) begin
      d.mode = MODE_BLANKS;
    end else if (b == BYTE_CR) begin
      d.run.cnt = 2'd1; d.run.b0 = BYTE_SP;
      d.mode    = MODE_AFTER_CR;
    end else if (b == BYTE_LF) begin
      d.run.cnt = 2'd1; d.run.b0 = BYTE_SP;
      d.mode    = MODE_NORMAL;
    end else begin
      d.mode    = n.mode;
      d.rem     = n.rem;
      d.run.cnt = n.run.cnt + 2'd1;
      d.run.b0  = BYTE_SP;
      d.run.b1  = n.run.b0;
      d.run.b2  = n.run.b1;
    end
    return d;
  endfunction

  always_comb begin
    dec_t d;
    d = '0;
    d.mode = mode_r;
    d.rem  = rem_r;
    if (in_end_of_text) begin
      d.mode = MODE_NORMAL;
      d.rem  = 2'd0;
      unique case (mode_r)
        MODE_AFTER_C2, MODE_BLANKS: begin
          d.run.cnt = 2'd2; d.run.b0 = BYTE_SP; d.run.b1 = BYTE_NUL;
        end
        MODE_AFTER_E2: begin
          d.run.cnt = 2'd2; d.run.b0 = BYTE_E2; d.run.b1 = BYTE_NUL;
        end
        MODE_E2_89: begin
          d.run.cnt = 2'd3; d.run.b0 = BYTE_E2; d.run.b1 = BYTE_89;
          d.run.b2  = BYTE_NUL;
        end
        default: begin
          d.run.cnt = 2'd1; d.run.b0 = BYTE_NUL;
        end
      endcase
      d.run.done = 1'b1;
    end else if (in_byte != BYTE_NUL) begin
      unique case (mode_r)
        MODE_AFTER_C2: begin
          if (in_byte == BYTE_AC) begin
            d.mode = MODE_BLANKS;
          end else if (in_byte >= BYTE_80 && in_byte <= BYTE_BF) begin
            d.run.cnt = 2'd2; d.run.b0 = BYTE_C2; d.run.b1 = in_byte;
            d.mode    = MODE_NORMAL;
          end else begin
            d = blank_fn(in_byte, rem_r);
          end
        end
        MODE_BLANKS: d = blank_fn(in_byte, rem_r);
        MODE_AFTER_E2: begin
          if (in_byte == BYTE_89) begin
            d.mode = MODE_E2_89;
          end else begin
            d.run.cnt = 2'd2; d.run.b0 = BYTE_E2; d.run.b1 = in_byte;
            d.rem     = 2'd1;
            d.mode    = MODE_COPY;
          end
        end
        MODE_E2_89: begin
          d.mode    = MODE_NORMAL;
          d.run.cnt = 2'd2;
          if (in_byte == BYTE_A0) begin
            d.run.b0 = BYTE_LT; d.run.b1 = BYTE_GT;
          end else if (in_byte == BYTE_A4) begin
            d.run.b0 = BYTE_LT; d.run.b1 = BYTE_EQ;
          end else if (in_byte == BYTE_A5) begin
            d.run.b0 = BYTE_GT; d.run.b1 = BYTE_EQ;
          end else begin
            d.run.cnt = 2'd3; d.run.b0 = BYTE_E2; d.run.b1 = BYTE_89;
            d.run.b2  = in_byte;
          end
        end
        MODE_COPY: begin
          d.run.cnt = 2'd1; d.run.b0 = in_byte;
          d.rem     = (rem_r != 2'd0) ? rem_r - 2'd1 : 2'd0;
          d.mode    = (d.rem == 2'd0) ? MODE_NORMAL : MODE_COPY;
        end
        MODE_AFTER_CR: begin
          if (in_byte == BYTE_LF) begin
            d.mode = MODE_NORMAL;
          end else begin
            d = normal_fn(in_byte, rem_r);
          end
        end
        default: d = normal_fn(in_byte, rem_r);
      endcase
    end
    mode_nxt = d.mode;
    rem_nxt  = d.rem;
    run      = d.run;
  end

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign q_push     = accept && (run.cnt != 2'd0);
  assign q_run      = run;
  assign front_mode = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      rem_r  <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/stn_queue.sv
// ----------------------------------------------------------------------------
// Script text normalizer run queue
// Small FIFO of result runs between the decoder and the output serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module stn_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire stn_pkg::run_t        push_run,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output stn_pkg::run_t             head_run,
  output logic [stn_pkg::Q_AW:0]    level
);
  import stn_pkg::*;

  run_t            entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_run   = entry_r[rd_ptr_r];
  assign level      = count_r;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_run;
  end

endmodule

`default_nettype wire

FILE: rtl/core/stn_back.sv
// ----------------------------------------------------------------------------
// Script text normalizer back end
// Serializes queued runs into single result bytes through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stn_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire stn_pkg::run_t head_run,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run,
  output logic               out_text_done
);
  import stn_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, done_r;
  logic [1:0] idx_r;
  logic       load, is_last;
  logic [7:0] sel_byte;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head_run.b0;
      2'd1:    sel_byte = head_run.b1;
      default: sel_byte = head_run.b2;
    endcase
  end

  assign is_last = (idx_r == head_run.cnt - 2'd1);
  assign load    = head_valid && (!valid_r || out_ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      last_r <= is_last;
      done_r <= is_last && head_run.done;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;
  assign out_text_done   = done_r;

endmodule

`default_nettype wire

FILE: rtl/core/script_text_normalizer.sv
// ----------------------------------------------------------------------------
// Script text normalizer
// Input channel in_*: one text byte per transaction, or an end-of-text mark.
// Output channel out_*: one normalized byte per transaction. out_last_of_run
// flags the final byte caused by an input transaction; out_text_done flags the
// zero terminator that closes the text.
// Throughput: one input transaction per cycle while in_ready is high and one
// output byte per cycle while out_ready is high. An input byte that expands
// to two or three bytes is sent out one byte at a time; the four-entry run
// queue absorbs short bursts of them before in_ready drops.
// Path: the first byte of a run is written into a queue entry and then
// loaded into the output register, which raises out_valid.
// Bytes that only change decoder state produce no output.
// Reset: decoder in normal mode, queue empty, out_valid low.
// Receiver stall: the output register holds its byte, the queue fills, and
// in_ready goes low while the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_text_normalizer_macros.svh"

module script_text_normalizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_text_done
);
  import stn_pkg::*;

  logic          q_full, q_push, q_pop, q_head_valid;
  run_t          q_run, q_head_run;
  logic [Q_AW:0] q_level;
  mode_t         front_mode;

  stn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_run          (q_run),
    .front_mode     (front_mode)
  );

  stn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_run   (q_run),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_run   (q_head_run),
    .level      (q_level)
  );

  stn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_run        (q_head_run),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_text_done   (out_text_done)
  );

  `STN_ASSERT(a_end_resets_mode, (in_valid && in_ready && in_end_of_text) |=> (front_mode == MODE_NORMAL), "decoder not in normal mode after end of text")
  `STN_ASSERT(a_done_is_last, (out_valid && out_text_done) |-> (out_last_of_run && (out_byte == BYTE_NUL)), "terminator is not a zero last byte")
  `STN_ASSERT(a_zero_only_done, (out_valid && (out_byte == BYTE_NUL)) |-> out_text_done, "zero byte emitted without terminator flag")
  `STN_ASSERT_NEVER(a_queue_overflow, q_level > (Q_AW+1)'(Q_DEPTH), "run queue level beyond depth")

endmodule

`default_nettype wire

FILE: tb/tb_script_text_normalizer.sv
// ----------------------------------------------------------------------------
// Script text normalizer testbench
// Drives text bytes and end-of-text marks through the valid/ready input
// channel and checks every output transaction against a typed row or a local
// model of the normalizer. A short table of directed rows comes first, then a
// long stream of mostly well-formed script fragments with random content and
// some noise. Both sides idle in random bursts, and the receiver stalls once
// for a long stretch so that the block fills up and drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_script_text_normalizer;

  timeunit 1ns;
  timeprecision 1ps;

  import stn_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } in_item_t;

  // Directed row: input byte, end flag, typed-result flag, result count and
  // up to three result bytes, first byte in the top lane.
  typedef struct packed {
    logic [7:0]  b;
    logic        eot;
    logic        typed;
    logic [1:0]  n;
    logic [23:0] e;
  } row_t;

  localparam int N_DIR = 29;

  localparam row_t DIR_ROWS [N_DIR] = '{
    {8'h41,    1'b0, 1'b1, 2'd1, {8'h41, 16'h0}},
    {8'h01,    1'b0, 1'b1, 2'd1, {8'h01, 16'h0}},
    {8'hFF,    1'b0, 1'b1, 2'd1, {8'hFF, 16'h0}},
    {BYTE_NUL, 1'b0, 1'b1, 2'd0, 24'h0},
    {BYTE_AD,  1'b0, 1'b1, 2'd2, {BYTE_LT, BYTE_GT, 8'h0}},
    {BYTE_B2,  1'b0, 1'b1, 2'd2, {BYTE_LT, BYTE_EQ, 8'h0}},
    {BYTE_B3,  1'b0, 1'b1, 2'd2, {BYTE_GT, BYTE_EQ, 8'h0}},
    {BYTE_CR,  1'b0, 1'b1, 2'd1, {BYTE_LF, 16'h0}},
    {BYTE_LF,  1'b0, 1'b1, 2'd0, 24'h0},
    {BYTE_E2,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_89,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_A5,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_E2,  1'b0, 1'b0, 2'd0, 24'h0},
    {8'h41,    1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_C2,  1'b0, 1'b0, 2'd0, 24'h0},
    {8'hA9,    1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_C2,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_AC,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_SP,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_CR,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_LF,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_F4,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_CR,  1'b0, 1'b0, 2'd0, 24'h0},
    {8'hFF,    1'b1, 1'b0, 2'd0, 24'h0},
    {BYTE_E2,  1'b0, 1'b0, 2'd0, 24'h0},
    {BYTE_89,  1'b0, 1'b0, 2'd0, 24'h0},
    {8'h00,    1'b1, 1'b0, 2'd0, 24'h0},
    {BYTE_C2,  1'b0, 1'b0, 2'd0, 24'h0},
    {8'h5A,    1'b1, 1'b0, 2'd0, 24'h0}
  };

  localparam int N_RANDOM = 350;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       out_text_done;

  mode_t      text_mode;
  logic [1:0] raw_left;
  out_item_t  run_bytes [$];
  out_item_t  pending_bytes [$];
  in_item_t   text_stream [$];

  int err_cnt = 0;
  bit quiet = 1'b0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  script_text_normalizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_text_done   (out_text_done)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Normalizer model
  // ---------------------------------------------------------------------------

  function automatic void put_byte(input logic [7:0] b, input logic done);
    if (run_bytes.size() < 3) run_bytes.push_back('{b, 1'b0, done});
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    text_mode = MODE_NORMAL;
    if (b == BYTE_C2) begin
      text_mode = MODE_AFTER_C2;
    end else if (b == BYTE_E2) begin
      text_mode = MODE_AFTER_E2;
    end else if (b == BYTE_AD) begin
      put_byte(BYTE_LT, 1'b0);
      put_byte(BYTE_GT, 1'b0);
    end else if (b == BYTE_B2) begin
      put_byte(BYTE_LT, 1'b0);
      put_byte(BYTE_EQ, 1'b0);
    end else if (b == BYTE_B3) begin
      put_byte(BYTE_GT, 1'b0);
      put_byte(BYTE_EQ, 1'b0);
    end else if (b >= BYTE_C2 && b <= BYTE_F4) begin
      put_byte(b, 1'b0);
      raw_left = (b >= BYTE_F0) ? 2'd3 : ((b >= BYTE_E0) ? 2'd2 : 2'd1);
      text_mode = MODE_COPY;
    end else if (b == BYTE_CR) begin
      put_byte(BYTE_LF, 1'b0);
      text_mode = MODE_AFTER_CR;
    end else begin
      put_byte(b, 1'b0);
    end
  endfunction

  // Byte seen while a line continuation is still swallowing blanks.
  function automatic void blank_or_break(input logic [7:0] b);
    if (b == BYTE_SP || b == BYTE_TAB) begin
      text_mode = MODE_BLANKS;
    end else if (b == BYTE_CR) begin
      put_byte(BYTE_SP, 1'b0);
      text_mode = MODE_AFTER_CR;
    end else if (b == BYTE_LF) begin
      put_byte(BYTE_SP, 1'b0);
      text_mode = MODE_NORMAL;
    end else begin
      put_byte(BYTE_SP, 1'b0);
      plain_byte(b);
    end
  endfunction

  function automatic void close_text();
    case (text_mode)
      MODE_AFTER_C2, MODE_BLANKS: put_byte(BYTE_SP, 1'b0);
      MODE_AFTER_E2: put_byte(BYTE_E2, 1'b0);
      MODE_E2_89: begin
        put_byte(BYTE_E2, 1'b0);
        put_byte(BYTE_89, 1'b0);
      end
      default: ;
    endcase
    put_byte(BYTE_NUL, 1'b1);
    text_mode = MODE_NORMAL;
    raw_left = 2'd0;
  endfunction

  function automatic void text_byte(input logic [7:0] b);
    case (text_mode)
      MODE_AFTER_C2: begin
        if (b == BYTE_AC) begin
          text_mode = MODE_BLANKS;
        end else if (b >= BYTE_80 && b <= BYTE_BF) begin
          put_byte(BYTE_C2, 1'b0);
          put_byte(b, 1'b0);
          text_mode = MODE_NORMAL;
        end else begin
          blank_or_break(b);
        end
      end
      MODE_BLANKS: blank_or_break(b);
      MODE_AFTER_E2: begin
        if (b == BYTE_89) begin
          text_mode = MODE_E2_89;
        end else begin
          put_byte(BYTE_E2, 1'b0);
          put_byte(b, 1'b0);
          raw_left = 2'd1;
          text_mode = MODE_COPY;
        end
      end
      MODE_E2_89: begin
        text_mode = MODE_NORMAL;
        if (b == BYTE_A0) begin
          put_byte(BYTE_LT, 1'b0);
          put_byte(BYTE_GT, 1'b0);
        end else if (b == BYTE_A4) begin
          put_byte(BYTE_LT, 1'b0);
          put_byte(BYTE_EQ, 1'b0);
        end else if (b == BYTE_A5) begin
          put_byte(BYTE_GT, 1'b0);
          put_byte(BYTE_EQ, 1'b0);
        end else begin
          put_byte(BYTE_E2, 1'b0);
          put_byte(BYTE_89, 1'b0);
          put_byte(b, 1'b0);
        end
      end
      MODE_COPY: begin
        put_byte(b, 1'b0);
        if (raw_left > 2'd0) raw_left = raw_left - 2'd1;
        if (raw_left == 2'd0) text_mode = MODE_NORMAL;
      end
      MODE_AFTER_CR: begin
        if (b == BYTE_LF) text_mode = MODE_NORMAL;
        else plain_byte(b);
      end
      default: plain_byte(b);
    endcase
  endfunction

  // Fills run_bytes with what one input transaction produces.
  function automatic void predict_run(input logic [7:0] b, input logic eot);
    run_bytes.delete();
    if (eot) close_text();
    else if (b != BYTE_NUL) text_byte(b);
    if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic offer(input logic [7:0] b, input logic eot, input bit typed,
                       input int n, input logic [23:0] e);
    int k;
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_run(b, eot);
    if (typed) begin
      run_bytes.delete();
      for (k = 0; k < n; k++) begin
        run_bytes.push_back('{e[23 - 8 * k -: 8], k == n - 1, eot && (k == n - 1)});
      end
    end
    foreach (run_bytes[j]) pending_bytes.push_back(run_bytes[j]);
  endtask

  task automatic sender_gap();
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic add_in(input logic [7:0] b, input logic eot);
    text_stream.push_back('{b, eot});
  endtask

  function automatic logic [7:0] ascii_char();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // One script fragment: mostly well-formed constructs, some noise.
  task automatic add_fragment();
    int         pick;
    logic [7:0] lead;
    int         tail;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      add_in(ascii_char(), 1'b0);
    end else if (pick < 33) begin
      add_in(BYTE_CR, 1'b0);
    end else if (pick < 37) begin
      add_in(BYTE_CR, 1'b0);
      add_in(BYTE_LF, 1'b0);
    end else if (pick < 40) begin
      add_in($urandom_range(0, 1) ? BYTE_LF : BYTE_TAB, 1'b0);
    end else if (pick < 46) begin
      case ($urandom_range(0, 2))
        0: add_in(BYTE_AD, 1'b0);
        1: add_in(BYTE_B2, 1'b0);
        default: add_in(BYTE_B3, 1'b0);
      endcase
    end else if (pick < 54) begin
      add_in(BYTE_E2, 1'b0);
      add_in(BYTE_89, 1'b0);
      case ($urandom_range(0, 2))
        0: add_in(BYTE_A0, 1'b0);
        1: add_in(BYTE_A4, 1'b0);
        default: add_in(BYTE_A5, 1'b0);
      endcase
    end else if (pick < 57) begin
      add_in(BYTE_E2, 1'b0);
      add_in(BYTE_89, 1'b0);
      add_in(8'($urandom_range(1, 255)), 1'b0);
    end else if (pick < 60) begin
      add_in(BYTE_E2, 1'b0);
      add_in(8'($urandom_range(1, 255)), 1'b0);
      add_in(8'($urandom_range(1, 255)), 1'b0);
    end else if (pick < 64) begin
      add_in(BYTE_C2, 1'b0);
      add_in(8'($urandom_range(BYTE_80, BYTE_BF)), 1'b0);
    end else if (pick < 72) begin
      // Line continuation, with or without the AC byte.
      add_in(BYTE_C2, 1'b0);
      if ($urandom_range(0, 1)) add_in(BYTE_AC, 1'b0);
      repeat ($urandom_range(0, 3)) add_in($urandom_range(0, 1) ? BYTE_SP : BYTE_TAB, 1'b0);
      case ($urandom_range(0, 3))
        0: add_in(BYTE_CR, 1'b0);
        1: begin
          add_in(BYTE_CR, 1'b0);
          add_in(BYTE_LF, 1'b0);
        end
        2: add_in(BYTE_LF, 1'b0);
        default: ;
      endcase
      add_in(ascii_char(), 1'b0);
    end else if (pick < 78) begin
      lead = 8'($urandom_range(8'hC3, BYTE_F4));
      tail = (lead >= BYTE_F0) ? 3 : ((lead >= BYTE_E0) ? 2 : 1);
      add_in(lead, 1'b0);
      repeat (tail) begin
        if ($urandom_range(0, 3) == 0) add_in(8'($urandom_range(1, 255)), 1'b0);
        else add_in(8'($urandom_range(BYTE_80, BYTE_BF)), 1'b0);
      end
    end else if (pick < 86) begin
      add_in(8'($urandom_range(1, 255)), 1'b0);
    end else if (pick < 89) begin
      add_in(BYTE_NUL, 1'b0);
    end else if (pick < 93) begin
      add_in(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      add_in(ascii_char(), 1'b0);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    text_mode      = MODE_NORMAL;
    raw_left       = 2'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      offer(DIR_ROWS[i].b, DIR_ROWS[i].eot, DIR_ROWS[i].typed, DIR_ROWS[i].n, DIR_ROWS[i].e);
      sender_gap();
    end

    while (text_stream.size() < N_RANDOM) add_fragment();
    add_in(8'($urandom_range(0, 255)), 1'b1);

    foreach (text_stream[i]) begin
      if (i == 120) begin
        hold_req = 1'b1;
        quiet    = 1'b1;
      end
      if (i == 200) quiet = 1'b0;
      if (i == text_stream.size() - 60) calm = 1'b1;
      offer(text_stream[i].b, text_stream[i].eot, 1'b0, 0, 24'h0);
      sender_gap();
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("script_text_normalizer test passed");
    end else begin
      $display("script_text_normalizer test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        // Long stall while the sender keeps going, so the run queue fills.
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_out
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output transaction: out_byte=%h", out_byte);
        err_cnt++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.b) begin
          $error("out_byte: expected %h, actual %h", want.b, out_byte);
          err_cnt++;
        end
        if (out_last_of_run !== want.last) begin
          $error("out_last_of_run: expected %b, actual %b", want.last, out_last_of_run);
          err_cnt++;
        end
        if (out_text_done !== want.done) begin
          $error("out_text_done: expected %b, actual %b", want.done, out_text_done);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #200000;
    $display("script_text_normalizer test failed");
    $finish;
  end

endmodule

`default_nettype wire
